/* src/nbsc_pkg.sv */
// Package for the nearest band separation check: widths, constants, codes and types.
// No dependencies.
`timescale 1ns / 1ps
package nbsc_pkg;
  localparam int MaxBands = 8;
  localparam int SlotW = $clog2(MaxBands);
  localparam int FreqW = 24;
  localparam int DistW = 42;
  localparam int QuotW = 42;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_ASSESS = 1'b1;
  localparam logic [3:0] REG_BAND_COUNT = 4'd0;
  localparam logic [3:0] REG_MARGIN = 4'd1;

  typedef struct packed {
    logic [15:0]          mode;
    logic [FreqW-1:0]     freq;
    logic [FreqW-1:0]     unc;
    logic [SlotW-1:0]     slot;
    logic signed [DistW-1:0] distance;
  } job_t;
endpackage

/* src/nearest_band_separation_check.sv */
// Top level of the nearest band separation check: config registers, front, queue, back.
// Depends on nbsc_pkg, nbsc_front, nbsc_queue, nbsc_back.
//
// Channel  | Handshake            | Payload
// in       | in_valid / in_stall  | command, band_slot, band_min_hz ... mode_number
// out      | out_valid / out_stall| mode_number_out, frequency_out, nearest_band, ...
// cfg      | cfg_we, cfg_index    | cfg_data
//
// A load writes the band table. An assess with a nonzero band count stalls the input
// for a walk through a two-stage read and multiply path, then the handoff to the queue.
// The back end accepts a job, divides (one quotient bit a cycle) and registers the
// result; a zero frequency skips the divide. It stalls the queue until its result is
// registered, so it takes no new job before then.
// Reset is synchronous; the band table is not cleared. A stalled output holds;
// the queue lets the front start the next walk while the back waits.
`timescale 1ns / 1ps
module nearest_band_separation_check (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic command,
  input  logic [2:0] band_slot,
  input  logic [23:0] band_min_hz,
  input  logic [23:0] band_max_hz,
  input  logic [23:0] mode_frequency,
  input  logic [23:0] mode_uncertainty,
  input  logic [15:0] mode_number,
  input  logic cfg_we,
  input  logic [3:0] cfg_index,
  input  logic [15:0] cfg_data,
  output logic out_valid,
  input  logic out_stall,
  output logic [15:0] mode_number_out,
  output logic [23:0] frequency_out,
  output logic [2:0] nearest_band,
  output logic signed [31:0] separation,
  output logic overlaps
);
  import nbsc_pkg::*;
  logic [3:0] band_count;
  logic [15:0] margin_fraction;
  logic fv, fs, qv, qs;
  job_t fj, qj;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_count <= '0;
      margin_fraction <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_BAND_COUNT) band_count <= cfg_data[3:0];
      else if (cfg_index == REG_MARGIN) margin_fraction <= cfg_data;
    end
  end

  nbsc_front u_front (.clk, .rst, .in_valid, .in_stall, .command, .band_slot,
    .band_min_hz, .band_max_hz, .mode_frequency, .mode_uncertainty, .mode_number,
    .count(band_count), .margin(margin_fraction),
    .job_valid(fv), .job(fj), .job_stall(fs));
  nbsc_queue u_queue (.clk, .rst, .wr_valid(fv), .wr_stall(fs), .wr_data(fj),
    .rd_valid(qv), .rd_stall(qs), .rd_data(qj));
  nbsc_back u_back (.clk, .rst, .job_valid(qv), .job_stall(qs), .job(qj),
    .out_valid, .out_stall, .mode_number_out, .frequency_out, .nearest_band,
    .separation, .overlaps);
endmodule

/* src/nbsc_front.sv */
// Front end: band table, band walk with multipliers, nearest band search.
// Depends on nbsc_pkg.
`timescale 1ns / 1ps
module nbsc_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic command,
  input  logic [2:0] band_slot,
  input  logic [23:0] band_min_hz,
  input  logic [23:0] band_max_hz,
  input  logic [23:0] mode_frequency,
  input  logic [23:0] mode_uncertainty,
  input  logic [15:0] mode_number,
  input  logic [3:0] count,
  input  logic [15:0] margin,
  output logic job_valid,
  output nbsc_pkg::job_t job,
  input  logic job_stall
);
  import nbsc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;
  logic [FreqW-1:0] low_mem [MaxBands];
  logic [FreqW-1:0] high_mem [MaxBands];
  logic [SlotW:0] idx;
  logic [SlotW:0] limit;
  logic [FreqW-1:0] lo_q, hi_q;
  logic signed [DistW-1:0] lo_p, hi_p, fs, a, b, d;
  logic signed [DistW-1:0] best;
  logic [SlotW-1:0] best_slot;
  logic have_best;
  logic [SlotW-1:0] rd_slot;
  logic [15:0] mode_q;
  logic [FreqW-1:0] freq_q, unc_q;
  logic accept;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign limit = (count > 4'(MaxBands)) ? (SlotW+1)'(MaxBands) : (SlotW+1)'(count);
  assign fs = DistW'({freq_q, 16'h0000});
  // Products are registered (lo_q/hi_q read, then multiplied into lo_p/hi_p).
  always_ff @(posedge clk) begin
    lo_q <= low_mem[idx[SlotW-1:0]];
    hi_q <= high_mem[idx[SlotW-1:0]];
    rd_slot <= idx[SlotW-1:0];
    lo_p <= DistW'(lo_q * (17'h10000 - 17'(margin)));
    hi_p <= DistW'(hi_q * (17'h10000 + 17'(margin)));
    if (accept && command == CMD_LOAD) begin
      low_mem[band_slot[SlotW-1:0]] <= band_min_hz;
      high_mem[band_slot[SlotW-1:0]] <= band_max_hz;
    end
  end

  always_comb begin
    a = fs - lo_p;
    b = hi_p - fs;
    if (fs < lo_p) d = lo_p - fs;
    else if (fs > hi_p) d = fs - hi_p;
    else d = (a < b) ? -a : -b;
  end

  // Pipeline: idx read -> lo_q (1) -> lo_p (2) -> compare. Two valid stages.
  logic [1:0] vpipe;
  logic [SlotW-1:0] slot_p;
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept && command == CMD_ASSESS && limit != '0) state_next = S_WALK;
      S_WALK: if (idx == limit && vpipe == 2'b00) state_next = S_DONE;
      S_DONE: if (!job_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      vpipe <= '0;
      have_best <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        idx <= '0;
        vpipe <= '0;
        have_best <= 1'b0;
        if (accept) begin
          mode_q <= mode_number;
          freq_q <= mode_frequency;
          unc_q <= mode_uncertainty;
        end
      end else if (state == S_WALK) begin
        vpipe <= {vpipe[0], idx != limit};
        if (idx != limit) idx <= idx + 1'b1;
        slot_p <= rd_slot;
        if (vpipe[1] && (!have_best || d < best)) begin
          best <= d;
          best_slot <= slot_p;
          have_best <= 1'b1;
        end
      end
    end
  end

  assign job_valid = (state == S_DONE);
  assign job.mode = mode_q;
  assign job.freq = freq_q;
  assign job.unc = unc_q;
  assign job.slot = best_slot;
  assign job.distance = best;
endmodule

/* src/nbsc_queue.sv */
// Two-entry queue between front and back ends.
// Depends on nbsc_pkg.
`timescale 1ns / 1ps
module nbsc_queue (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_stall,
  input  nbsc_pkg::job_t wr_data,
  output logic rd_valid,
  input  logic rd_stall,
  output nbsc_pkg::job_t rd_data
);
  import nbsc_pkg::*;
  job_t mem [2];
  logic wp, rp;
  logic [1:0] fill;
  logic push, pop;

  assign wr_stall = (fill == 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign push = wr_valid && !wr_stall;
  assign pop = rd_valid && !rd_stall;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_data;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end
endmodule

/* src/nbsc_back.sv */
// Back end: serial divider for the separation, saturation and output register.
// Depends on nbsc_pkg.
`timescale 1ns / 1ps
module nbsc_back (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_stall,
  input  nbsc_pkg::job_t job,
  output logic out_valid,
  input  logic out_stall,
  output logic [15:0] mode_number_out,
  output logic [23:0] frequency_out,
  output logic [2:0] nearest_band,
  output logic signed [31:0] separation,
  output logic overlaps
);
  import nbsc_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_OUT  = 3'b100
  } bstate_t;

  bstate_t state;
  logic [QuotW-1:0] quo;
  logic [FreqW:0] rem;
  logic [FreqW-1:0] dvs;
  logic [5:0] step;
  logic neg;
  job_t hold;
  logic [DistW-1:0] mag;
  logic [FreqW:0] trial;
  logic [QuotW-1:0] q;
  logic signed [QuotW:0] sq;

  assign job_stall = (state != B_IDLE);
  assign mag = job.distance[DistW-1] ? DistW'(-job.distance) : job.distance;
  assign trial = {rem[FreqW-1:0], quo[QuotW-1]};
  assign q = (hold.freq == '0) ? QuotW'(quo >> 8) : quo;
  assign sq = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        B_IDLE: if (job_valid) begin
          hold <= job;
          neg <= job.distance[DistW-1];
          quo <= mag;
          rem <= '0;
          dvs <= job.freq;
          step <= '0;
          state <= (job.freq == '0) ? B_OUT : B_DIV;
        end
        B_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (trial >= {1'b0, dvs}) begin
            rem <= trial - {1'b0, dvs};
            quo <= {quo[QuotW-2:0], 1'b1};
          end else begin
            rem <= trial;
            quo <= {quo[QuotW-2:0], 1'b0};
          end
          step <= step + 1'b1;
          if (step == 6'(QuotW-1)) state <= B_OUT;
        end
        B_OUT: if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
          mode_number_out <= hold.mode;
          frequency_out <= hold.freq;
          nearest_band <= 3'(hold.slot);
          overlaps <= (hold.distance <= $signed(DistW'({hold.unc, 16'h0000})));
          if (sq > 43'sh0_7FFF_FFFF) separation <= 32'sh7FFF_FFFF;
          else if (sq < -43'sh0_8000_0000) separation <= 32'sh8000_0000;
          else separation <= 32'(sq);
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
      if (out_valid && !out_stall && !(state == B_OUT)) out_valid <= 1'b0;
    end
  end
endmodule

/* src/nbsc_checker.sv */
// Port-level checker for the nearest band separation check, bound to the top level.
// Depends on nearest_band_separation_check.
`timescale 1ns / 1ps
module nbsc_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic [15:0] mode_number_out,
  input logic signed [31:0] separation,
  input logic overlaps
);
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("out_valid dropped");
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(separation) && $stable(mode_number_out))
    else $error("stalled result changed");
  a_inside_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid && separation < 0 |-> overlaps) else $error("inside band without overlap");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");
endmodule

bind nearest_band_separation_check nbsc_checker u_checker (.clk, .rst, .out_valid,
  .out_stall, .mode_number_out, .separation, .overlaps);

/* sim/tb.sv */
// Testbench for nearest_band_separation_check: random and directed band loads and mode
// assessments, checked against an in-bench predictor of the nearest band search.
// Depends on nbsc_pkg and the nearest_band_separation_check RTL.
`timescale 1ns / 1ps
module tb;
  import nbsc_pkg::*;

  typedef struct {
    logic        cmd;
    logic [2:0]  slot;
    logic [23:0] bmin;
    logic [23:0] bmax;
    logic [23:0] freq;
    logic [23:0] unc;
    logic [15:0] mode;
  } item_t;

  typedef struct {
    logic [15:0]        mode;
    logic [23:0]        freq;
    logic [2:0]         slot;
    logic signed [31:0] sep;
    logic               ovl;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = 1'b0;
  logic [2:0] band_slot = '0;
  logic [23:0] band_min_hz = '0, band_max_hz = '0, mode_frequency = '0, mode_uncertainty = '0;
  logic [15:0] mode_number = '0;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] mode_number_out;
  logic [23:0] frequency_out;
  logic [2:0] nearest_band;
  logic signed [31:0] separation;
  logic overlaps;

  nearest_band_separation_check uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  item_t    pending_items[$];
  verdict_t expected_verdicts[$];
  int       error_count = 0;
  bit       hold_long = 1'b0;

  // Predictor state.
  logic [23:0] low_edge[8];
  logic [23:0] high_edge[8];
  logic [3:0]  active_bands = '0;
  logic [15:0] margin = '0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic add_item(input item_t it);
    pending_items = {pending_items, it};
  endtask

  task automatic assess_mode(input item_t it);
    longint fs, us, lo, hi, d, best_d, sep, mag;
    int count, best;
    verdict_t v;
    if (it.cmd == CMD_LOAD) begin
      low_edge[it.slot] = it.bmin;
      high_edge[it.slot] = it.bmax;
      return;
    end
    count = active_bands > MaxBands ? MaxBands : active_bands;
    if (count == 0) return;
    fs = longint'(it.freq) * 65536;
    us = longint'(it.unc) * 65536;
    best_d = 0;
    best = 0;
    for (int i = 0; i < count; i++) begin
      lo = longint'(low_edge[i]) * (65536 - longint'(margin));
      hi = longint'(high_edge[i]) * (65536 + longint'(margin));
      if (fs < lo) d = lo - fs;
      else if (fs > hi) d = fs - hi;
      else d = -(((fs - lo) < (hi - fs)) ? (fs - lo) : (hi - fs));
      if (i == 0 || d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    if (it.freq != 0) sep = best_d / longint'(it.freq);
    else begin
      mag = best_d < 0 ? -best_d : best_d;
      mag = mag >>> 8;
      sep = best_d < 0 ? -mag : mag;
    end
    if (sep > 64'sd2147483647) sep = 64'sd2147483647;
    if (sep < -64'sd2147483648) sep = -64'sd2147483648;
    v.mode = it.mode;
    v.freq = it.freq;
    v.slot = best[2:0];
    v.sep = sep[31:0];
    v.ovl = best_d <= us;
    expected_verdicts = {expected_verdicts, v};
  endtask

  // Acceptance seen at the last rising edge.
  bit in_stall_seen = 1'b1;
  bit burst_mode = 1'b0;
  always @(posedge clk) in_stall_seen <= !(in_valid && !in_stall);

  // Driver: one transfer per accepted item, with a random gap after each (none in burst mode).
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_stall_seen) begin
        // Still waiting for acceptance; payload holds.
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_items.size() > 0) begin
        item_t it;
        it = pending_items.pop_front();
        assess_mode(it);
        command <= it.cmd;
        band_slot <= it.slot;
        band_min_hz <= it.bmin;
        band_max_hz <= it.bmax;
        mode_frequency <= it.freq;
        mode_uncertainty <= it.unc;
        mode_number <= it.mode;
        in_valid <= 1'b1;
        send_gap <= burst_mode ? 0 : $urandom_range(0, 11);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern.
  int recv_gap = 0;
  int long_hold = 0;
  always @(negedge clk) begin
    if (hold_long && long_hold == 0) long_hold = 600;
    if (long_hold > 0) begin
      out_stall <= 1'b1;
      long_hold--;
      if (long_hold == 0) hold_long = 1'b0;
    end else if (recv_gap > 0) begin
      out_stall <= 1'b1;
      recv_gap--;
    end else begin
      out_stall <= 1'b0;
      if (out_valid) recv_gap = burst_mode ? 0 : $urandom_range(0, 11);
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        report("unexpected result, mode_number_out", mode_number_out, -1);
      end else begin
        verdict_t v;
        v = expected_verdicts.pop_front();
        if (mode_number_out !== v.mode) report("mode_number_out", mode_number_out, v.mode);
        if (frequency_out !== v.freq) report("frequency_out", frequency_out, v.freq);
        if (nearest_band !== v.slot) report("nearest_band", nearest_band, v.slot);
        if (separation !== v.sep) report("separation", separation, v.sep);
        if (overlaps !== v.ovl) report("overlaps", overlaps, v.ovl);
      end
    end
  end

  function automatic logic [23:0] pick_freq();
    case ($urandom_range(0, 5))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(0, 255));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic item_t load_item(input logic [2:0] s, input logic [23:0] a,
                                      input logic [23:0] b);
    item_t it;
    it.cmd = CMD_LOAD;
    it.slot = s;
    it.bmin = a;
    it.bmax = b;
    it.freq = 24'($urandom);
    it.unc = 24'($urandom);
    it.mode = 16'($urandom);
    return it;
  endfunction

  function automatic item_t mode_item(input logic [23:0] f, input logic [23:0] u);
    item_t it;
    it.cmd = CMD_ASSESS;
    it.slot = 3'($urandom);
    it.bmin = 24'($urandom);
    it.bmax = 24'($urandom);
    it.freq = f;
    it.unc = u;
    it.mode = 16'($urandom);
    return it;
  endfunction

  task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BAND_COUNT) active_bands = val[3:0];
    else if (idx == REG_MARGIN) margin = val;
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && in_stall_seen && expected_verdicts.size() == 0);
    // An assess with no bands or a final load may still be in flight.
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [23:0] near_edge(input logic [23:0] e);
    int off;
    off = $urandom_range(0, 2000) - 1000;
    return 24'(int'(e) + off);
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill all slots before any band becomes active.
    for (int s = 0; s < 8; s++)
      add_item(load_item(3'(s), 24'(24'h000100 * (s + 1) * 16),
                         24'(24'h000100 * (s + 1) * 20)));
    drain();
    // No active bands: assess gives nothing.
    add_item(mode_item(24'h001000, 24'd0));
    drain();
    write_reg(REG_BAND_COUNT, 16'd8);
    write_reg(REG_MARGIN, 16'd0);
    // Unknown index is ignored.
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= 4'hF; cfg_data <= 16'hFFFF;
    @(negedge clk);
    cfg_we <= 1'b0;
    add_item(mode_item(24'd0, 24'd0));
    add_item(mode_item(24'hFFFFFF, 24'hFFFFFF));
    add_item(mode_item(24'h001400, 24'd0));
    add_item(mode_item(24'h001000, 24'd0));
    add_item(mode_item(24'd1, 24'd0));
    // Tie: identical bands in slots 2 and 3, inverted band in slot 4.
    add_item(load_item(3'd2, 24'h004000, 24'h005000));
    add_item(load_item(3'd3, 24'h004000, 24'h005000));
    add_item(load_item(3'd4, 24'h009000, 24'h008000));
    add_item(mode_item(24'h004800, 24'h000100));
    add_item(mode_item(24'h008800, 24'h000100));
    add_item(load_item(3'd7, 24'hFFFFFF, 24'hFFFFFF));
    add_item(load_item(3'd0, 24'd0, 24'd0));
    add_item(mode_item(24'd0, 24'hFFFFFF));
    drain();
    write_reg(REG_MARGIN, 16'hFFFF);
    add_item(mode_item(24'h004800, 24'd0));
    add_item(mode_item(24'hFFFFFF, 24'd0));
    drain();
    write_reg(REG_BAND_COUNT, 16'd15);  // above capacity acts as eight
    add_item(mode_item(24'h002000, 24'h000010));
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      write_reg(REG_BAND_COUNT, phase == 0 ? 16'd1 : 16'($urandom_range(1, 15)));
      write_reg(REG_MARGIN, phase == 1 ? 16'd0 : phase == 2 ? 16'hFFFF : 16'($urandom));
      if (phase == 3) begin
        burst_mode = 1'b1;
        hold_long = 1'b1;
      end
      for (int k = 0; k < 105; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          logic [23:0] a, b;
          a = pick_freq();
          b = $urandom_range(0, 4) == 0 ? pick_freq() : 24'(a + $urandom_range(0, 100000));
          add_item(load_item(3'($urandom), a, b));
        end else begin
          logic [23:0] f, u;
          int s;
          s = $urandom_range(0, 7);
          f = $urandom_range(0, 1) ? near_edge($urandom_range(0, 1) ? low_edge[s] : high_edge[s])
                                   : pick_freq();
          u = $urandom_range(0, 2) == 0 ? 24'd0 : ($urandom_range(0, 1) ? pick_freq()
                                                   : 24'($urandom_range(0, 2000)));
          add_item(mode_item(f, u));
        end
      end
      drain();
      burst_mode = 1'b0;
    end

    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
